// ----- rtl/rme_pkg.sv -----
// Shared types and constants of the RSA modular exponentiation unit.
// No dependencies; every other file imports this package.
package rme_pkg;

  // Default operand width
  localparam int VALUE_WIDTH_DEF = 16;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS      = 2'd0,
    CFG_PUBLIC_EXP   = 2'd1,
    CFG_PRIVATE_EXP  = 2'd2
  } cfg_idx_t;

  // Word mode codes
  typedef enum logic {
    MODE_ENCRYPT = 1'b0,
    MODE_DECRYPT = 1'b1
  } mode_t;

  // Controller states, one-hot
  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,  // waiting for a word
    ST_RED  = 8'b0000_0010,  // base mod n, one bit per cycle
    ST_RDN  = 8'b0000_0100,  // store reduced base, init accumulator
    ST_NEXT = 8'b0000_1000,  // start squaring for next exponent bit
    ST_SQR  = 8'b0001_0000,  // modular square in progress
    ST_MST  = 8'b0010_0000,  // start multiply by base
    ST_MUL  = 8'b0100_0000,  // modular multiply in progress
    ST_FIN  = 8'b1000_0000   // load result register
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;       // capture word and exponent
    logic red_step;   // one restoring step of base reduction
    logic red_done;   // latch reduced base, init accumulator
    logic mul_start;  // load multiplier operands
    logic mul_sq;     // with mul_start: square instead of times base
    logic mul_step;   // one interleaved modular multiply step
    logic bit_next;   // advance to next exponent bit
    logic out_load;   // write result register
  } rme_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic step_last;  // bit counter on last step
    logic exp_bit;    // current exponent bit (MSB first)
    logic exp_last;   // current exponent bit is the last one
    logic exp_zero;   // selected exponent is zero
  } rme_sts_t;

endpackage

// ----- rtl/rme_if.sv -----
// Valid/ready channel interfaces for the input and result words.
// Depends on rme_pkg for the default width.
interface rme_in_if import rme_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic                   mode;
  logic [VALUE_WIDTH-1:0] base_value;

  modport source (output valid, output mode, output base_value, input ready);
  modport sink   (input valid, input mode, input base_value, output ready);
endinterface

interface rme_out_if import rme_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] result_value;

  modport source (output valid, output result_value, input ready);
  modport sink   (input valid, input result_value, output ready);
endinterface

// ----- rtl/rme_datapath.sv -----
// Datapath: config registers, base reduction and shift-add modular multiplier.
// Depends on rme_pkg; driven by rme_controller through rme_cmd_t.
module rme_datapath import rme_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [VALUE_WIDTH-1:0] cfg_wdata,
  input  logic                   in_mode,
  input  logic [VALUE_WIDTH-1:0] in_base,
  input  rme_cmd_t               cmd,
  output rme_sts_t               sts,
  output logic [VALUE_WIDTH-1:0] result
);

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(W);

  logic [W-1:0]  modulus_r, pub_exp_r, priv_exp_r;
  logic [W:0]    mod_r;       // effective modulus, 2^W when n is zero
  logic [W-1:0]  exp_r;       // exponent, shifted out MSB first
  logic          ezero_r;
  logic [W-1:0]  base_r;      // raw base, shifted out during reduction
  logic [W-1:0]  bm_r;        // reduced base
  logic [W-1:0]  acc_r;       // remainder during reduction, then power
  logic [W-1:0]  a_r;         // multiplicand
  logic [W-1:0]  mb_r;        // multiplier, MSB first
  logic [W-1:0]  p_r;         // partial product mod n
  logic [CW-1:0] cnt_r;       // step counter
  logic [CW-1:0] ecnt_r;      // exponent bit counter
  logic [W-1:0]  res_r;

  logic [W-1:0]  sel_exp;
  logic          step_last;
  logic [W:0]    r_sh, r_sub;
  logic [W-1:0]  red_val;
  logic [W+1:0]  s_sum, m1, m2;
  logic [W-1:0]  p_val;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r  <= W'(1);
      pub_exp_r  <= W'(1);
      priv_exp_r <= W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODULUS:     modulus_r  <= cfg_wdata;
        CFG_PUBLIC_EXP:  pub_exp_r  <= cfg_wdata;
        CFG_PRIVATE_EXP: priv_exp_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign sel_exp   = (in_mode == MODE_DECRYPT) ? priv_exp_r : pub_exp_r;
  assign step_last = (cnt_r == CW'(W - 1));

  // Restoring reduction step: remainder stays below modulus
  assign r_sh    = {acc_r, base_r[W-1]};
  assign r_sub   = r_sh - mod_r;
  assign red_val = (r_sh >= mod_r) ? r_sub[W-1:0] : r_sh[W-1:0];

  // Interleaved multiply step: 2p + bit*a is below 3n, fold once or twice
  assign s_sum = {1'b0, p_r, 1'b0} + {2'b00, (mb_r[W-1] ? a_r : '0)};
  assign m1    = {1'b0, mod_r};
  assign m2    = {mod_r, 1'b0};
  always_comb begin
    p_val = s_sum[W-1:0];
    if (s_sum >= m2) begin
      p_val = W'(s_sum - m2);
    end else if (s_sum >= m1) begin
      p_val = W'(s_sum - m1);
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mod_r   <= (modulus_r == '0) ? {1'b1, {W{1'b0}}} : {1'b0, modulus_r};
      exp_r   <= sel_exp;
      ezero_r <= (sel_exp == '0);
      base_r  <= in_base;
      acc_r   <= '0;
    end
    if (cmd.red_step) begin
      acc_r  <= red_val;
      base_r <= {base_r[W-2:0], 1'b0};
    end
    if (cmd.red_done) begin
      bm_r  <= acc_r;
      acc_r <= (mod_r == (W+1)'(1)) ? '0 : W'(1);
    end
    if (cmd.mul_start) begin
      a_r  <= cmd.mul_sq ? acc_r : bm_r;
      mb_r <= acc_r;
      p_r  <= '0;
    end
    if (cmd.mul_step) begin
      p_r  <= p_val;
      mb_r <= {mb_r[W-2:0], 1'b0};
      if (step_last) begin
        acc_r <= p_val;
      end
    end
    if (cmd.bit_next) begin
      exp_r <= {exp_r[W-2:0], 1'b0};
    end
    if (cmd.out_load) begin
      res_r <= ezero_r ? W'(1) : acc_r;
    end
  end

  // Counters
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.load) begin
      cnt_r  <= '0;
      ecnt_r <= '0;
    end else begin
      if (cmd.red_step || cmd.mul_step) begin
        cnt_r <= step_last ? '0 : cnt_r + CW'(1);
      end
      if (cmd.bit_next) begin
        ecnt_r <= (ecnt_r == CW'(W - 1)) ? '0 : ecnt_r + CW'(1);
      end
    end
  end

  assign sts.step_last = step_last;
  assign sts.exp_bit   = exp_r[W-1];
  assign sts.exp_last  = (ecnt_r == CW'(W - 1));
  assign sts.exp_zero  = ezero_r;
  assign result        = res_r;

endmodule

// ----- rtl/rme_controller.sv -----
// Controller FSM sequencing reduction, square and multiply steps.
// Depends on rme_pkg; commands rme_datapath.
module rme_controller import rme_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  rme_sts_t sts,
  output rme_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RED;
        end
      end
      ST_RED: begin
        cmd.red_step = 1'b1;
        if (sts.step_last) state_nxt = ST_RDN;
      end
      ST_RDN: begin
        cmd.red_done = 1'b1;
        state_nxt    = sts.exp_zero ? ST_FIN : ST_NEXT;
      end
      ST_NEXT: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sq    = 1'b1;
        state_nxt     = ST_SQR;
      end
      ST_SQR: begin
        cmd.mul_step = 1'b1;
        if (sts.step_last) begin
          if (sts.exp_bit) begin
            state_nxt = ST_MST;
          end else begin
            cmd.bit_next = 1'b1;
            state_nxt    = sts.exp_last ? ST_FIN : ST_NEXT;
          end
        end
      end
      ST_MST: begin
        cmd.mul_start = 1'b1;
        state_nxt     = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.step_last) begin
          cmd.bit_next = 1'b1;
          state_nxt    = sts.exp_last ? ST_FIN : ST_NEXT;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output word valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ----- rtl/rsa_modular_exponentiation_unit.sv -----
// Top level of the RSA modular exponentiation unit.
// Depends on rme_pkg, rme_if, rme_controller and rme_datapath.
//   in_ch  : valid/ready word with mode (0 public, 1 private exponent) and
//            base_value. A word is taken only while the unit is idle.
//   out_ch : valid/ready word carrying base_value ^ e mod n.
//   cfg_*  : write modulus (0), public exponent (1), private exponent (2)
//            while idle; other indexes are ignored.
// Sequence, from the accepting edge to out_ch.valid: reduce the base (ST_RED),
//   store it and init the accumulator (ST_RDN), then per exponent bit a
//   square (ST_NEXT, ST_SQR) plus a multiply by the base (ST_MST, ST_MUL)
//   when the bit is set, then load the output register (ST_FIN). The single
//   shift-add modular multiplier handles one multiplier bit per cycle. A zero
//   exponent skips the bit loop, still runs the base reduction and returns 1.
// Between words: a new word is taken only once the unit is back in idle,
//   after the last result has been loaded into the output register.
// Reset (synchronous, active low) returns the configuration registers to 1 and drops
//   out_ch.valid. A stalled result is held in the output register; the next
//   word is accepted meanwhile and waits in its final cycle until the slot
//   frees up.
module rsa_modular_exponentiation_unit import rme_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  rme_in_if.sink                 in_ch,
  rme_out_if.source              out_ch,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [VALUE_WIDTH-1:0] cfg_wdata
);

  rme_cmd_t cmd;
  rme_sts_t sts;

  rme_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rme_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_mode   (in_ch.mode),
    .in_base   (in_ch.base_value),
    .cmd       (cmd),
    .sts       (sts),
    .result    (out_ch.result_value)
  );

endmodule

// ----- rtl/rme_checker.sv -----
// Port-level checks for the RSA modular exponentiation unit, with bind.
// Depends on rme_pkg and rsa_modular_exponentiation_unit.
module rme_checker import rme_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [VALUE_WIDTH-1:0] out_data
);

  // Stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word dropped or changed while stalled");

  // Unit is busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in a row");

  // New result only at the end of a computation
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while idle");

  // Reset empties the output
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind rsa_modular_exponentiation_unit rme_checker #(
  .VALUE_WIDTH (VALUE_WIDTH)
) u_rme_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.result_value)
);
